/* design/bhtar_pkg.sv */
// Shared constants and types for the bucketed hash table.
package bhtar_pkg;

   localparam int KEY_W   = 64;
   localparam int SCORE_W = 16;
   localparam int GEN_W   = 6;
   localparam int ACT_W   = 2;

   // action codes
   localparam logic [ACT_W-1:0] ACT_PROBE   = 2'd0;
   localparam logic [ACT_W-1:0] ACT_RECORD  = 2'd1;
   localparam logic [ACT_W-1:0] ACT_ADVANCE = 2'd2;

   // generation counter limits
   localparam logic [GEN_W-1:0] GEN_LIMIT = 6'd63;
   localparam logic [GEN_W-1:0] GEN_FIRST = 6'd1;

   // remainder unit: key bits consumed per cycle
   localparam int DIGIT_W = 4;
   localparam int STEPS   = KEY_W / DIGIT_W;

   typedef struct packed {
      logic [KEY_W-1:0]          key;
      logic signed [SCORE_W-1:0] score;
   } kv_type;

   typedef struct packed {
      logic rd_en;
      logic kv_wr;
      logic gen_wr;
   } mem_cmd_type;

endpackage

/* design/bhtar_req_if.sv */
// Request channel: action, key and score with valid/ready.
interface bhtar_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [bhtar_pkg::ACT_W-1:0]            action;
   logic [bhtar_pkg::KEY_W-1:0]            lookup_key;
   logic signed [bhtar_pkg::SCORE_W-1:0]   new_score;

   modport source (output valid, action, lookup_key, new_score, input ready);
   modport sink   (input valid, action, lookup_key, new_score, output ready);
endinterface

/* design/bhtar_rsp_if.sv */
// Response channel: hit flag, score and generation with valid/ready.
interface bhtar_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   hit;
   logic signed [bhtar_pkg::SCORE_W-1:0]   found_score;
   logic [bhtar_pkg::GEN_W-1:0]            found_generation;

   modport source (output valid, hit, found_score, found_generation, input ready);
   modport sink   (input valid, hit, found_score, found_generation, output ready);
endinterface

/* design/bhtar_set_index.sv */
// Set index unit: key modulo SETS (mask, or a digit-serial remainder).
module bhtar_set_index #(
   parameter int SETS = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [bhtar_pkg::KEY_W-1:0]   key,
   output logic                          done,
   output logic [((SETS > 1) ? $clog2(SETS) : 1)-1:0] idx
);

   localparam int  IDX_W = (SETS > 1) ? $clog2(SETS) : 1;
   localparam bit  POW2  = ((SETS & (SETS - 1)) == 0);

   generate
      if (POW2) begin : g_mask
         assign done = start;
         if (SETS == 1) begin : g_one
            assign idx = '0;
         end else begin : g_bits
            assign idx = key[IDX_W-1:0];
         end
      end else begin : g_serial
         localparam int T_W   = IDX_W + bhtar_pkg::DIGIT_W;
         localparam int CNT_W = $clog2(bhtar_pkg::STEPS);

         logic [bhtar_pkg::KEY_W-1:0] shift_ff;
         logic [IDX_W-1:0]            rem_ff;
         logic [IDX_W-1:0]            rem_in;
         logic [CNT_W-1:0]            cnt_ff;
         logic                        busy_ff;
         logic                        done_ff;
         logic [T_W-1:0]              partial;
         logic [T_W-1:0]              sub;

         // rem' = (rem * 16 + digit) mod SETS; pick the largest multiple not above it
         always_comb begin
            partial = {rem_ff, shift_ff[bhtar_pkg::KEY_W-1 -: bhtar_pkg::DIGIT_W]};
            sub     = '0;
            for (int k = 1; k < (1 << bhtar_pkg::DIGIT_W); k++) begin
               if (partial >= T_W'(k * SETS)) begin
                  sub = T_W'(k * SETS);
               end
            end
            rem_in = IDX_W'(partial - sub);
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b0;
               cnt_ff  <= '0;
            end else begin
               done_ff <= 1'b0;
               if (start) begin
                  busy_ff <= 1'b1;
                  cnt_ff  <= '0;
               end else if (busy_ff) begin
                  cnt_ff <= cnt_ff + 1'b1;
                  if (cnt_ff == CNT_W'(bhtar_pkg::STEPS - 1)) begin
                     busy_ff <= 1'b0;
                     done_ff <= 1'b1;
                  end
               end
            end
         end

         always_ff @(posedge clock) begin
            if (start) begin
               shift_ff <= key;
               rem_ff   <= '0;
            end else if (busy_ff) begin
               shift_ff <= shift_ff << bhtar_pkg::DIGIT_W;
               rem_ff   <= rem_in;
            end
         end

         assign done = done_ff;
         assign idx  = rem_ff;
      end
   endgenerate

endmodule

/* design/bhtar_mem.sv */
// Set memories: key/score rows and generation rows, one set per row.
module bhtar_mem #(
   parameter int SETS = 1024,
   parameter int WAYS = 4
) (
   input  logic                               clock,
   input  bhtar_pkg::mem_cmd_type             cmd,
   input  logic [((SETS > 1) ? $clog2(SETS) : 1)-1:0] rd_addr,
   input  logic [((SETS > 1) ? $clog2(SETS) : 1)-1:0] wr_addr,
   input  bhtar_pkg::kv_type [WAYS-1:0]       kv_wdata,
   input  logic [WAYS-1:0][bhtar_pkg::GEN_W-1:0] gen_wdata,
   output bhtar_pkg::kv_type [WAYS-1:0]       kv_rdata,
   output logic [WAYS-1:0][bhtar_pkg::GEN_W-1:0] gen_rdata
);

   bhtar_pkg::kv_type [WAYS-1:0]             kv_ram  [SETS];
   logic [WAYS-1:0][bhtar_pkg::GEN_W-1:0]    gen_ram [SETS];
   bhtar_pkg::kv_type [WAYS-1:0]             kv_rd_ff;
   logic [WAYS-1:0][bhtar_pkg::GEN_W-1:0]    gen_rd_ff;

   always_ff @(posedge clock) begin
      if (cmd.kv_wr) begin
         kv_ram[wr_addr] <= kv_wdata;
      end
      if (cmd.rd_en) begin
         kv_rd_ff <= kv_ram[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.gen_wr) begin
         gen_ram[wr_addr] <= gen_wdata;
      end
      if (cmd.rd_en) begin
         gen_rd_ff <= gen_ram[rd_addr];
      end
   end

   assign kv_rdata  = kv_rd_ff;
   assign gen_rdata = gen_rd_ff;

endmodule

/* design/bucketed_hash_table_age_replace.sv */
// Top level: set-associative key/score table with generation-age replacement.
//
// Usage notes
//  - req_ch transfers one action (probe, record, advance generation) with its key
//    and score; rsp_ch returns exactly one result per request, in order.
//  - Probe: hit flag, stored score and the refreshed (current) generation on a hit,
//    zeros on a miss. Record and advance always answer with all-zero fields.
//  - Steps per request when SETS is a power of two: set read, then compare and
//    write-back. Otherwise a remainder unit taking 4 key bits per cycle forms the
//    set index first. A new request is only taken once the last is written back.
//  - Reset (synchronous): both set memories are swept to zero, one set per cycle;
//    req_ch.ready stays low until done. Generation restarts at 1.
//  - When the generation wraps from 62, the generation memory is swept to zero
//    with req_ch.ready low.
//  - A finished result sits in the output register; the next request is still
//    taken, but its write-back waits until rsp_ch has taken the old result.
module bucketed_hash_table_age_replace #(
   parameter int SETS = 1024,
   parameter int WAYS = 4
) (
   input  logic                clock,
   input  logic                reset,
   bhtar_req_if.sink           req_ch,
   bhtar_rsp_if.source         rsp_ch
);

   localparam int IDX_W = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int LEAVES = 1 << WAY_W;

   typedef enum logic [4:0] {
      ST_CLEAR_ALL = 5'b00001,
      ST_CLEAR_GEN = 5'b00010,
      ST_IDLE      = 5'b00100,
      ST_INDEX     = 5'b01000,
      ST_UPDATE    = 5'b10000
   } state_type;

   state_type                              state_ff, state_in;
   logic [IDX_W-1:0]                       clr_cnt_ff, clr_cnt_in;
   logic [bhtar_pkg::GEN_W-1:0]            cur_gen_ff, cur_gen_in;

   // captured request
   logic [bhtar_pkg::ACT_W-1:0]            act_ff;
   logic [bhtar_pkg::KEY_W-1:0]            key_ff;
   logic signed [bhtar_pkg::SCORE_W-1:0]   score_ff;
   logic [IDX_W-1:0]                       idx_ff;

   // output register
   logic                                   rsp_valid_ff;
   logic                                   hit_ff;
   logic signed [bhtar_pkg::SCORE_W-1:0]   fscore_ff;
   logic [bhtar_pkg::GEN_W-1:0]            fgen_ff;
   logic                                   rsp_load;
   logic                                   hit_in;
   logic signed [bhtar_pkg::SCORE_W-1:0]   fscore_in;
   logic [bhtar_pkg::GEN_W-1:0]            fgen_in;

   logic                                   req_xfer;
   logic                                   table_op;
   logic                                   idx_start;
   logic                                   idx_done;
   logic [IDX_W-1:0]                       idx_val;
   logic                                   out_free;

   bhtar_pkg::mem_cmd_type                 mem_cmd;
   logic [IDX_W-1:0]                       wr_addr;
   bhtar_pkg::kv_type [WAYS-1:0]           kv_wdata, kv_rdata;
   logic [WAYS-1:0][bhtar_pkg::GEN_W-1:0]  gen_wdata, gen_rdata;

   // set lookup results
   logic                                   any_match;
   logic [WAY_W-1:0]                       match_way;
   logic signed [bhtar_pkg::SCORE_W-1:0]   match_score;
   logic [WAY_W-1:0]                       victim_way;
   logic [WAY_W-1:0]                       rec_way;
   logic [bhtar_pkg::GEN_W-1:0]            gen_plus;
   logic [bhtar_pkg::GEN_W-1:0]            node_gen [2*LEAVES-1];
   logic [WAY_W-1:0]                       node_way [2*LEAVES-1];

   assign req_xfer  = req_ch.valid && req_ch.ready;
   assign table_op  = (req_ch.action == bhtar_pkg::ACT_PROBE) ||
                      (req_ch.action == bhtar_pkg::ACT_RECORD);
   assign idx_start = req_xfer && table_op;
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign gen_plus  = cur_gen_ff + 1'b1;

   bhtar_set_index #(.SETS(SETS)) u_index (
      .clock (clock),
      .reset (reset),
      .start (idx_start),
      .key   (req_ch.lookup_key),
      .done  (idx_done),
      .idx   (idx_val)
   );

   bhtar_mem #(.SETS(SETS), .WAYS(WAYS)) u_mem (
      .clock     (clock),
      .cmd       (mem_cmd),
      .rd_addr   (idx_val),
      .wr_addr   (wr_addr),
      .kv_wdata  (kv_wdata),
      .gen_wdata (gen_wdata),
      .kv_rdata  (kv_rdata),
      .gen_rdata (gen_rdata)
   );

   // lowest matching way
   always_comb begin
      any_match   = 1'b0;
      match_way   = '0;
      match_score = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (kv_rdata[w].key == key_ff) begin
            any_match   = 1'b1;
            match_way   = WAY_W'(w);
            match_score = kv_rdata[w].score;
         end
      end
   end

   // oldest way: min tree, left wins ties so the lowest way is taken.
   // Padding leaves carry 63, above any stored generation.
   always_comb begin
      for (int i = 0; i < LEAVES; i++) begin
         node_way[LEAVES-1+i] = WAY_W'(i);
         node_gen[LEAVES-1+i] = (i < WAYS) ? gen_rdata[i % WAYS] : bhtar_pkg::GEN_LIMIT;
      end
      for (int n = LEAVES - 2; n >= 0; n--) begin
         if (node_gen[2*n+1] <= node_gen[2*n+2]) begin
            node_gen[n] = node_gen[2*n+1];
            node_way[n] = node_way[2*n+1];
         end else begin
            node_gen[n] = node_gen[2*n+2];
            node_way[n] = node_way[2*n+2];
         end
      end
      victim_way = node_way[0];
   end

   assign rec_way = any_match ? match_way : victim_way;

   // sequencer
   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      cur_gen_in = cur_gen_ff;
      mem_cmd    = '0;
      wr_addr    = idx_ff;
      kv_wdata   = kv_rdata;
      gen_wdata  = gen_rdata;
      rsp_load   = 1'b0;
      hit_in     = 1'b0;
      fscore_in  = '0;
      fgen_in    = '0;

      unique case (state_ff) inside
         ST_CLEAR_ALL, ST_CLEAR_GEN: begin
            mem_cmd.gen_wr = 1'b1;
            mem_cmd.kv_wr  = (state_ff == ST_CLEAR_ALL);
            wr_addr        = clr_cnt_ff;
            kv_wdata       = '0;
            gen_wdata      = '0;
            if (clr_cnt_ff == IDX_W'(SETS - 1)) begin
               clr_cnt_in = '0;
               state_in   = ST_IDLE;
            end else begin
               clr_cnt_in = clr_cnt_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_xfer) begin
               if (table_op && idx_done) begin
                  mem_cmd.rd_en = 1'b1;
                  state_in      = ST_UPDATE;
               end else if (table_op) begin
                  state_in = ST_INDEX;
               end else begin
                  state_in = ST_UPDATE;
               end
            end
         end
         ST_INDEX: begin
            if (idx_done) begin
               mem_cmd.rd_en = 1'b1;
               state_in      = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
               case (act_ff)
                  bhtar_pkg::ACT_PROBE: begin
                     if (any_match) begin
                        mem_cmd.gen_wr = 1'b1;
                        for (int w = 0; w < WAYS; w++) begin
                           if (WAY_W'(w) == match_way) begin
                              gen_wdata[w] = cur_gen_ff;
                           end
                        end
                        hit_in    = 1'b1;
                        fscore_in = match_score;
                        fgen_in   = cur_gen_ff;
                     end
                  end
                  bhtar_pkg::ACT_RECORD: begin
                     mem_cmd.kv_wr  = 1'b1;
                     mem_cmd.gen_wr = 1'b1;
                     for (int w = 0; w < WAYS; w++) begin
                        if (WAY_W'(w) == rec_way) begin
                           kv_wdata[w].key   = key_ff;
                           kv_wdata[w].score = score_ff;
                           gen_wdata[w]      = cur_gen_ff;
                        end
                     end
                  end
                  bhtar_pkg::ACT_ADVANCE: begin
                     if (gen_plus == bhtar_pkg::GEN_LIMIT) begin
                        cur_gen_in = bhtar_pkg::GEN_FIRST;
                        clr_cnt_in = '0;
                        state_in   = ST_CLEAR_GEN;
                     end else begin
                        cur_gen_in = gen_plus;
                     end
                  end
                  default: begin
                     // unused action code: no state change, zero result
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR_ALL;
         clr_cnt_ff   <= '0;
         cur_gen_ff   <= bhtar_pkg::GEN_FIRST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
         cur_gen_ff <= cur_gen_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         act_ff   <= req_ch.action;
         key_ff   <= req_ch.lookup_key;
         score_ff <= req_ch.new_score;
      end
      if (mem_cmd.rd_en) begin
         idx_ff <= idx_val;
      end
      if (rsp_load) begin
         hit_ff    <= hit_in;
         fscore_ff <= fscore_in;
         fgen_ff   <= fgen_in;
      end
   end

   assign req_ch.ready            = (state_ff == ST_IDLE);
   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.hit              = hit_ff;
   assign rsp_ch.found_score      = fscore_ff;
   assign rsp_ch.found_generation = fgen_ff;

endmodule
